/* sv/rnsalu_pkg.sv */
`timescale 1ns / 1ps
package rnsalu_pkg;

	typedef enum logic [2:0] {
		ACT_SET  = 3'd0,
		ACT_ADD  = 3'd1,
		ACT_SUB  = 3'd2,
		ACT_MUL  = 3'd3,
		ACT_MULS = 3'd4
	} action_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [3:0]  lane;
		logic [31:0] a_residue;
		logic [31:0] b_residue;
		logic [63:0] scalar;
	} req_t;

	typedef struct packed {
		logic [31:0] result;
		logic [3:0]  lane_out;
	} res_t;

	localparam int MaxLanes = 9;

	// Each modulus is 2^32 - c with c below 2^9.
	function automatic logic [8:0] lane_c(logic [3:0] lane);
		logic [8:0] c;
		case (lane)
			4'd0:    c = 9'd483;
			4'd1:    c = 9'd419;
			4'd2:    c = 9'd369;
			4'd3:    c = 9'd315;
			4'd4:    c = 9'd267;
			4'd5:    c = 9'd185;
			4'd6:    c = 9'd135;
			4'd7:    c = 9'd99;
			4'd8:    c = 9'd17;
			default: c = 9'd0;
		endcase
		return c;
	endfunction

	// First fold: x = hi*2^32 + lo is congruent to hi*c + lo.
	function automatic logic [41:0] fold_hi(logic [63:0] x, logic [8:0] c);
		return ({10'd0, x[63:32]} * {33'd0, c}) + {10'd0, x[31:0]};
	endfunction

endpackage

/* sv/rnsalu_red.sv */
`timescale 1ns / 1ps
module rnsalu_red (
	input  logic [41:0] x,
	input  logic [8:0]  c,
	output logic [31:0] r
);
	import rnsalu_pkg::*;

	logic [32:0] v;
	logic [32:0] m;

	// Second fold leaves v below 2^32 + 2^19, so one subtract of m finishes it.
	assign v = ({23'd0, x[41:32]} * {24'd0, c}) + {1'b0, x[31:0]};
	assign m = 33'h1_0000_0000 - {24'd0, c};
	assign r = (v >= m) ? 32'(v - m) : v[31:0];

endmodule

/* sv/rns_lane_modular_alu_top.sv */
`timescale 1ns / 1ps
// Channel | Valid     | Stall     | Payload
// request | req_valid | req_stall | req (action, lane, a_residue, b_residue, scalar)
// result  | res_valid | res_stall | res (result, lane_out)
//
// Five-stage pipeline: one request per cycle while the output stage is not stalled.
// Stages: scalar fold, scalar reduce, 32x32 multiply, fold, reduce (output register).
// The one 32x32 multiplier is in stage three.
// arst_n clears the valid bits only; data registers carry no reset.
// A stalled full output stage freezes the whole pipe and raises req_stall.
module rns_lane_modular_alu_top #(
	parameter int NUM_LANES = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  rnsalu_pkg::req_t  req,
	output logic              res_valid,
	input  logic              res_stall,
	output rnsalu_pkg::res_t  res
);
	import rnsalu_pkg::*;

	logic en;

	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [2:0]  act_s1, act_s2;
	logic [3:0]  lane_s1, lane_s2, lane_s3, lane_s4, lane_s5;
	logic        ok_s1, ok_s2, ok_s3, ok_s4;
	logic [8:0]  c_s1, c_s2, c_s3, c_s4;
	logic [31:0] a_s1, a_s2, b_s1, b_s2;
	logic [63:0] x_s1, x_s2;
	logic [41:0] sf_s1;
	logic [31:0] sred;
	logic [31:0] s_s2_r;
	logic [63:0] p_s3;
	logic [41:0] f_s4;
	logic [31:0] fred;
	logic [31:0] result_s5;

	logic [63:0] x_in;
	logic [8:0]  c_in;
	logic        ok_in;
	logic [31:0] mul_b;
	logic [63:0] p_next;

	assign en        = !(valid_s5 && res_stall);
	assign req_stall = !en;

	assign c_in  = lane_c(req.lane);
	assign ok_in = (req.lane < 4'(NUM_LANES)) && (req.lane < 4'(MaxLanes))
	             && (req.action <= 3'(ACT_MULS));

	always_comb begin
		case (action_t'(req.action))
			ACT_SET: x_in = req.scalar;
			ACT_ADD: x_in = {32'd0, req.a_residue} + {32'd0, req.b_residue};
			ACT_SUB: x_in = {32'd0, req.a_residue} - {32'd0, req.b_residue}
			              + (64'h1_0000_0000 - {55'd0, c_in});
			default: x_in = req.scalar;
		endcase
	end

	rnsalu_red u_sred (.x(sf_s1), .c(c_s1), .r(sred));

	always_comb begin
		case (action_t'(act_s2))
			ACT_MUL:  mul_b = b_s2;
			ACT_MULS: mul_b = s_s2_r;
			default:  mul_b = b_s2;
		endcase
		if (act_s2 == 3'(ACT_MUL) || act_s2 == 3'(ACT_MULS)) begin
			p_next = {32'd0, a_s2} * {32'd0, mul_b};
		end else begin
			p_next = x_s2;
		end
	end

	rnsalu_red u_fred (.x(f_s4), .c(c_s4), .r(fred));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1  <= req.action;
			lane_s1 <= req.lane;
			ok_s1   <= ok_in;
			c_s1    <= c_in;
			a_s1    <= req.a_residue;
			b_s1    <= req.b_residue;
			x_s1    <= x_in;
			sf_s1   <= fold_hi(req.scalar, c_in);

			act_s2  <= act_s1;
			lane_s2 <= lane_s1;
			ok_s2   <= ok_s1;
			c_s2    <= c_s1;
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			x_s2    <= x_s1;
			s_s2_r  <= sred;

			lane_s3 <= lane_s2;
			ok_s3   <= ok_s2;
			c_s3    <= c_s2;
			p_s3    <= p_next;

			lane_s4 <= lane_s3;
			ok_s4   <= ok_s3;
			c_s4    <= c_s3;
			f_s4    <= fold_hi(p_s3, c_s3);

			lane_s5   <= lane_s4;
			result_s5 <= ok_s4 ? fred : 32'd0;
		end
	end

	assign res_valid    = valid_s5;
	assign res.result   = result_s5;
	assign res.lane_out = lane_s5;

endmodule

/* sv/rnsalu_chk.sv */
`timescale 1ns / 1ps
module rnsalu_chk #(
	parameter int NUM_LANES = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_stall,
	input  rnsalu_pkg::req_t req,
	input  logic             res_valid,
	input  logic             res_stall,
	input  rnsalu_pkg::res_t res
);
	import rnsalu_pkg::*;

	// A request is held back only behind a blocked result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (res_valid && res_stall))
		else $error("request stalled without a blocked result");

	// Hold a stalled request unchanged.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_stall) |=> (req_valid && $stable(req)))
		else $error("stalled request changed");

	// Every result lies below the largest modulus.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.result < 32'd4294967279))
		else $error("result not reduced");

	// Lanes outside the table give zero.
	a_bad_lane: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.lane_out >= 4'(NUM_LANES)) |-> (res.result == 32'd0))
		else $error("out-of-range lane gave non-zero result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res)))
		else $error("stalled result changed");

endmodule

bind rns_lane_modular_alu_top rnsalu_chk #(.NUM_LANES(NUM_LANES)) u_rnsalu_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
